[design/wpps_pkg.sv]
`timescale 1ns / 1ps
// Package for the weighted pick block: status codes and the fixed width
// of the running total. Used by the top level and its checker.
package wpps_pkg;

    localparam int TOTAL_BITS = 22;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
    localparam int RAND_BITS = 32;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

endpackage

[design/wpps_prefix_ram.sv]
`timescale 1ns / 1ps
// Prefix-sum table: one write port and one read port with registered data.
// No dependencies.
module wpps_prefix_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 22
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/weighted_pick_prefix_search.sv]
`timescale 1ns / 1ps
// Weighted random pick over a table of appended weights, searched by prefix sum.
// Depends on wpps_pkg and wpps_prefix_ram.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one transaction per item:
//   kind 0 appends weight (first clears the table beforehand), kind 1 picks
//   an index using random_fraction as a fraction of 2^32. The output channel
//   (out_valid/out_ready) returns exactly one transaction per item with the
//   picked index, running total, entry count and a status code.
//   A load, or a pick on an empty or zero-total table, shows its result
//   on the cycle after acceptance. A valid pick passes through the 32 x 22
//   scaling multiply (S_MUL), then a table read (S_READ) and a compare
//   (S_CMP) for each binary-search step; a final S_READ closes the search
//   and S_DONE loads the output register. The table has a single read
//   port, so the search probes one entry at a time.
//   One item is in work at a time; in_ready is high while the sequencer is
//   idle and the output register is free or being emptied.
//   Reset empties the table (count and total go to zero) and drops out_valid.
//   When the receiver stalls, the result holds in the output register and a
//   finished pick waits in its last state until the register frees.
module weighted_pick_prefix_search #(
    parameter int MAX_ENTRIES = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 kind,
    input  logic                                 first,
    input  logic [WEIGHT_BITS-1:0]               weight,
    input  logic [wpps_pkg::RAND_BITS-1:0]       random_fraction,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [$clog2(MAX_ENTRIES)-1:0]       picked_index,
    output logic [wpps_pkg::TOTAL_BITS-1:0]      total_weight,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]     entry_count,
    output wpps_pkg::status_t                    status
);

    import wpps_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W = ((WEIGHT_BITS > TOTAL_BITS) ? WEIGHT_BITS : TOTAL_BITS) + 1;
    localparam int PROD_W = RAND_BITS + TOTAL_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_READ,
        S_CMP,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [TOTAL_BITS-1:0]  total_reg;
    logic [RAND_BITS-1:0]   rand_reg;
    logic [TOTAL_BITS-1:0]  target_reg;
    logic [IDX_W-1:0]       lo_reg;
    logic [IDX_W-1:0]       hi_reg;
    logic [IDX_W-1:0]       mid_reg;
    logic                   out_valid_reg;
    logic [IDX_W-1:0]       picked_reg;
    logic [TOTAL_BITS-1:0]  out_total_reg;
    logic [CNT_W-1:0]       out_count_reg;
    status_t                status_reg;

    logic                   in_fire;
    logic                   out_free;
    logic [CNT_W-1:0]       count_eff;
    logic [TOTAL_BITS-1:0]  total_eff;
    logic                   table_full;
    logic [SUM_W-1:0]       sum_wide;
    logic [TOTAL_BITS-1:0]  total_next;
    logic [CNT_W-1:0]       count_next;
    logic [PROD_W-1:0]      product;
    logic [IDX_W:0]         span;
    logic [IDX_W-1:0]       mid;
    logic                   search_more;
    logic                   ram_wr_en;
    logic                   ram_rd_en;
    logic [TOTAL_BITS-1:0]  ram_rd_data;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;

    // A first flag restarts the table before this weight is appended.
    assign count_eff  = first ? '0 : count_reg;
    assign total_eff  = first ? '0 : total_reg;
    assign table_full = (count_eff == CNT_W'(MAX_ENTRIES));
    assign sum_wide   = SUM_W'(total_eff) + SUM_W'(weight);
    assign total_next = (sum_wide > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                       : sum_wide[TOTAL_BITS-1:0];
    assign count_next = count_eff + CNT_W'(1);
    assign ram_wr_en  = in_fire && !kind && !table_full;

    assign product = PROD_W'(rand_reg) * PROD_W'(total_reg);

    // Upper-middle split so that lo always advances when the probe matches.
    assign span        = {1'b0, hi_reg} - {1'b0, lo_reg} + (IDX_W+1)'(1);
    assign mid         = lo_reg + span[IDX_W:1];
    assign search_more = (lo_reg < hi_reg);
    assign ram_rd_en   = (state_reg == S_READ) && search_more;

    wpps_prefix_ram #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W),
        .DATA_W (TOTAL_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_eff[IDX_W-1:0]),
        .wr_data (total_eff),
        .rd_en   (ram_rd_en),
        .rd_addr (mid),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            rand_reg      <= '0;
            target_reg    <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            out_valid_reg <= 1'b0;
            picked_reg    <= '0;
            out_total_reg <= '0;
            out_count_reg <= '0;
            status_reg    <= STATUS_OK;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (!kind)
                        begin
                            out_valid_reg <= 1'b1;
                            picked_reg    <= '0;
                            if (table_full)
                            begin
                                count_reg     <= count_eff;
                                total_reg     <= total_eff;
                                out_count_reg <= count_eff;
                                out_total_reg <= total_eff;
                                status_reg    <= STATUS_FULL;
                            end
                            else
                            begin
                                count_reg     <= count_next;
                                total_reg     <= total_next;
                                out_count_reg <= count_next;
                                out_total_reg <= total_next;
                                status_reg    <= STATUS_OK;
                            end
                        end
                        else if (count_reg == '0 || total_reg == '0)
                        begin
                            out_valid_reg <= 1'b1;
                            picked_reg    <= '0;
                            out_count_reg <= count_reg;
                            out_total_reg <= total_reg;
                            status_reg    <= STATUS_EMPTY;
                        end
                        else
                        begin
                            rand_reg  <= random_fraction;
                            lo_reg    <= '0;
                            hi_reg    <= IDX_W'(count_reg - CNT_W'(1));
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    target_reg <= product[PROD_W-1:RAND_BITS];
                    state_reg  <= S_READ;
                end
                S_READ:
                begin
                    if (search_more)
                    begin
                        mid_reg   <= mid;
                        state_reg <= S_CMP;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_CMP:
                begin
                    if (ram_rd_data <= target_reg)
                    begin
                        lo_reg <= mid_reg;
                    end
                    else
                    begin
                        hi_reg <= mid_reg - IDX_W'(1);
                    end
                    state_reg <= S_READ;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        picked_reg    <= lo_reg;
                        out_count_reg <= count_reg;
                        out_total_reg <= total_reg;
                        status_reg    <= STATUS_OK;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign picked_index = picked_reg;
    assign total_weight = out_total_reg;
    assign entry_count  = out_count_reg;
    assign status       = status_reg;

endmodule

[design/wpps_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the weighted pick block, attached by bind.
// Depends on wpps_pkg and weighted_pick_prefix_search.
module wpps_checker #(
    parameter int MAX_ENTRIES = 64
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [$clog2(MAX_ENTRIES)-1:0]       picked_index,
    input logic [wpps_pkg::TOTAL_BITS-1:0]      total_weight,
    input logic [$clog2(MAX_ENTRIES+1)-1:0]     entry_count,
    input wpps_pkg::status_t                    status
);

    import wpps_pkg::*;

    // A stalled result must hold its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(picked_index)
            && $stable(total_weight) && $stable(entry_count) && $stable(status))
        else $error("result changed while stalled");

    // A successful transaction always names an entry that exists.
    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_OK |-> picked_index < entry_count)
        else $error("picked index beyond entry count");

    a_fail_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> picked_index == '0)
        else $error("failed transaction carries a nonzero index");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_FULL |-> entry_count == MAX_ENTRIES)
        else $error("full status with table not full");

    a_empty_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_EMPTY |-> entry_count == '0 || total_weight == '0)
        else $error("empty status with weight present");

endmodule

bind weighted_pick_prefix_search wpps_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_wpps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .picked_index (picked_index),
    .total_weight (total_weight),
    .entry_count  (entry_count),
    .status       (status)
);

[tb/sv/tb_weighted_pick_prefix_search.sv]
`timescale 1ns / 1ps
// Self-checking bench for weighted_pick_prefix_search: load and pick traffic, checked
// against a prefix-sum predictor kept in step with every accepted transaction.
// Depends on wpps_pkg and the design files under design/.
module tb_weighted_pick_prefix_search;
    import wpps_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int WEIGHT_W = 16;
    localparam int RANDOM_ITEMS = 1850;
    localparam int CALM_TAIL = 150;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PICK = 1'b1;

    typedef struct {
        logic                  kind;
        logic                  first;
        logic [WEIGHT_W-1:0]   weight;
        logic [RAND_BITS-1:0]  fraction;
        bit                    drain;
    } stim_item_t;

    typedef struct {
        logic [5:0]            index;
        logic [TOTAL_BITS-1:0] total;
        logic [6:0]            count;
        status_t               status;
    } pick_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = KIND_LOAD;
    logic first = 1'b0;
    logic [WEIGHT_W-1:0] weight = '0;
    logic [RAND_BITS-1:0] random_fraction = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [5:0] picked_index;
    logic [TOTAL_BITS-1:0] total_weight;
    logic [6:0] entry_count;
    status_t status;

    stim_item_t   pending_items[$];
    pick_result_t expected_results[$];

    // Predictor state: prefix sum before each entry, entry count, running total.
    logic [TOTAL_BITS-1:0] prefix_tbl [TABLE_DEPTH];
    logic [6:0]            tbl_count = '0;
    logic [TOTAL_BITS-1:0] tbl_total = '0;

    int n_items = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    logic rx_hold = 1'b0;
    logic calm;

    assign calm = (n_accepted + CALM_TAIL >= n_items);

    weighted_pick_prefix_search #(
        .MAX_ENTRIES(TABLE_DEPTH),
        .WEIGHT_BITS(WEIGHT_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .first(first),
        .weight(weight),
        .random_fraction(random_fraction),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .picked_index(picked_index),
        .total_weight(total_weight),
        .entry_count(entry_count),
        .status(status)
    );

    always #2 clk = ~clk;

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic pick_result_t predict_result(logic k, logic f,
                                                    logic [WEIGHT_W-1:0] w,
                                                    logic [RAND_BITS-1:0] r);
        pick_result_t res;
        logic [TOTAL_BITS:0] sum;
        logic [RAND_BITS+TOTAL_BITS-1:0] scaled;
        logic [TOTAL_BITS-1:0] target;
        res.index = '0;
        res.status = STATUS_OK;
        if (k == KIND_LOAD)
        begin
            if (f)
            begin
                tbl_count = '0;
                tbl_total = '0;
            end
            if (tbl_count >= 7'(TABLE_DEPTH))
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                prefix_tbl[tbl_count] = tbl_total;
                sum = {1'b0, tbl_total} + (TOTAL_BITS+1)'(w);
                tbl_total = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
                tbl_count = tbl_count + 7'd1;
            end
        end
        else if (tbl_count == 0 || tbl_total == 0)
        begin
            res.status = STATUS_EMPTY;
        end
        else
        begin
            scaled = (RAND_BITS+TOTAL_BITS)'(r) * (RAND_BITS+TOTAL_BITS)'(tbl_total);
            target = scaled[RAND_BITS+TOTAL_BITS-1:RAND_BITS];
            // Prefix sums never decrease, so the last entry at or below the target wins.
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (i < tbl_count && prefix_tbl[i] <= target)
                    res.index = 6'(i);
            end
        end
        res.total = tbl_total;
        res.count = tbl_count;
        return res;
    endfunction

    function automatic void note_mismatch(string msg);
        if (n_errors < 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
        n_errors++;
    endfunction

    function automatic logic [WEIGHT_W-1:0] gen_weight(int style);
        logic [WEIGHT_W-1:0] w;
        w = WEIGHT_W'($urandom);
        if (style == 0)
        begin
            w = WEIGHT_W'($urandom_range(0, 3));
        end
        else if (style == 1)
        begin
            case ($urandom_range(0, 3))
                0: w = '0;
                1: w = '1;
                2: w = WEIGHT_W'(1);
                default: w = WEIGHT_W'($urandom);
            endcase
        end
        return w;
    endfunction

    function automatic logic [RAND_BITS-1:0] gen_fraction();
        logic [RAND_BITS-1:0] r;
        case ($urandom_range(0, 7))
            0: r = '0;
            1: r = '1;
            default: r = $urandom;
        endcase
        return r;
    endfunction

    function automatic void add_item(logic k, logic f, logic [WEIGHT_W-1:0] w,
                                     logic [RAND_BITS-1:0] r, bit drain);
        stim_item_t it;
        it.kind = k;
        it.first = f;
        it.weight = w;
        it.fraction = r;
        it.drain = drain;
        pending_items.push_back(it);
    endfunction

    // Sender: offers queued items, holds the payload until the transaction completes.
    always @(posedge clk)
    begin
        stim_item_t nxt;
        logic take;
        logic drive;
        int owed;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            take = in_valid && in_ready;
            drive = in_valid && !take;
            if (take)
            begin
                expected_results.push_back(predict_result(kind, first, weight,
                                                          random_fraction));
                n_accepted <= n_accepted + 1;
            end
            owed = n_accepted + int'(take) - n_checked;
            if (!drive)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap <= tx_gap - 1;
                end
                else if (pending_items.size() != 0 && !(pending_items[0].drain && owed != 0))
                begin
                    if (!calm && $urandom_range(0, 15) == 0)
                    begin
                        tx_gap <= $urandom_range(0, 16);
                    end
                    else
                    begin
                        nxt = pending_items.pop_front();
                        kind <= nxt.kind;
                        first <= nxt.first;
                        weight <= nxt.weight;
                        random_fraction <= nxt.fraction;
                        drive = 1'b1;
                    end
                end
            end
            in_valid <= drive;
        end
    end

    // Receiver back-pressure: random bursts, plus one long hold-off below.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (rx_hold)
        begin
            out_ready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap <= rx_gap - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 19) == 0)
        begin
            rx_gap <= $urandom_range(0, 16);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        wait (n_accepted >= 600);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Monitor: every output transaction is compared with the oldest prediction.
    always @(posedge clk)
    begin
        pick_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_checked <= n_checked + 1;
            if (expected_results.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result idx=%0d total=%0d count=%0d st=%0d",
                                        picked_index, total_weight, entry_count, status));
            end
            else
            begin
                want = expected_results.pop_front();
                if (picked_index !== want.index)
                    note_mismatch($sformatf("picked_index exp %0d got %0d",
                                            want.index, picked_index));
                if (total_weight !== want.total)
                    note_mismatch($sformatf("total_weight exp %0d got %0d",
                                            want.total, total_weight));
                if (entry_count !== want.count)
                    note_mismatch($sformatf("entry_count exp %0d got %0d",
                                            want.count, entry_count));
                if (status !== want.status)
                    note_mismatch($sformatf("status exp %0d got %0d", want.status, status));
            end
        end
    end

    initial
    begin
        int n_made;
        int set_no;
        int set_len;
        int style;
        int roll;
        bit drain_done;
        // Directed: picks on an empty and a zero-total table, zero weights that
        // must be skipped, weight and fraction extremes, table restarts.
        add_item(KIND_PICK, 1'b0, '0, 32'h1234_5678, 1'b0);
        add_item(KIND_PICK, 1'b1, '1, '1, 1'b0);
        add_item(KIND_LOAD, 1'b1, '0, '0, 1'b0);
        add_item(KIND_PICK, 1'b0, '0, '1, 1'b0);
        add_item(KIND_LOAD, 1'b0, '0, '1, 1'b0);
        add_item(KIND_LOAD, 1'b0, '1, '0, 1'b0);
        add_item(KIND_LOAD, 1'b0, '0, '0, 1'b0);
        add_item(KIND_LOAD, 1'b0, 16'd1, '0, 1'b0);
        add_item(KIND_PICK, 1'b0, '0, '0, 1'b0);
        add_item(KIND_PICK, 1'b0, '1, '1, 1'b0);
        add_item(KIND_PICK, 1'b0, '0, 32'h8000_0000, 1'b0);
        add_item(KIND_PICK, 1'b1, '0, 32'hFFFE_FFFF, 1'b0);
        add_item(KIND_LOAD, 1'b1, '1, '0, 1'b0);
        add_item(KIND_PICK, 1'b0, '0, '0, 1'b0);
        add_item(KIND_PICK, 1'b0, '0, '1, 1'b0);
        add_item(KIND_LOAD, 1'b0, 16'hAAAA, 32'h5555_5555, 1'b0);
        add_item(KIND_LOAD, 1'b0, 16'h5555, 32'hAAAA_AAAA, 1'b0);
        add_item(KIND_PICK, 1'b0, 16'hAAAA, 32'h5555_5555, 1'b0);
        add_item(KIND_PICK, 1'b0, 16'h5555, 32'hAAAA_AAAA, 1'b0);
        add_item(KIND_LOAD, 1'b1, 16'd1, '0, 1'b0);
        add_item(KIND_LOAD, 1'b0, 16'd1, '0, 1'b0);
        add_item(KIND_PICK, 1'b0, '0, 32'h7FFF_FFFF, 1'b0);
        add_item(KIND_PICK, 1'b0, '0, 32'h8000_0000, 1'b0);

        // Random: mostly whole sets (restart, loads, picks); some sets overflow
        // the table, the rest is loose noise.
        n_made = 0;
        set_no = 0;
        drain_done = 1'b0;
        while (n_made < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (set_no == 0)
                set_len = TABLE_DEPTH + 3;
            else if (roll < 8)
                set_len = $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 6);
            else if (roll < 82)
                set_len = $urandom_range(1, 12);
            else
                set_len = 0;
            if (set_len == 0)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    add_item(1'($urandom), $urandom_range(0, 3) == 0, WEIGHT_W'($urandom),
                             $urandom, 1'b0);
                    n_made++;
                end
            end
            else
            begin
                style = $urandom_range(0, 2);
                for (int j = 0; j < set_len; j++)
                begin
                    add_item(KIND_LOAD, j == 0, gen_weight(style), $urandom,
                             j == 0 && ((set_no >= 40 && !drain_done) ||
                                        $urandom_range(0, 24) == 0));
                    if (j == 0 && set_no >= 40)
                        drain_done = 1'b1;
                    n_made++;
                end
                repeat ($urandom_range(1, 6))
                begin
                    add_item(KIND_PICK, $urandom_range(0, 7) == 0, WEIGHT_W'($urandom),
                             gen_fraction(), 1'b0);
                    n_made++;
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        add_item(KIND_LOAD, 1'b0, gen_weight(style), $urandom, 1'b0);
                        n_made++;
                    end
                    repeat ($urandom_range(1, 3))
                    begin
                        add_item(KIND_PICK, 1'b0, WEIGHT_W'($urandom), gen_fraction(), 1'b0);
                        n_made++;
                    end
                end
            end
            set_no++;
        end
        n_items = pending_items.size();

        wait (n_accepted == n_items);
        wait (n_checked >= n_accepted);
        repeat (40) @(posedge clk);
        if (expected_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
design/wpps_pkg.sv
design/wpps_prefix_ram.sv
design/weighted_pick_prefix_search.sv
design/wpps_checker.sv
tb/sv/tb_weighted_pick_prefix_search.sv
